// File: rtl/bpfa_pkg.sv
// shared types, codes and constants of the bitmap page frame allocator
`default_nettype none

package bpfa_pkg;

	localparam int MAP_WORDS_DEF = 32;
	localparam int FRAME_SHIFT   = 12;
	localparam int WORD_BITS     = 32;
	localparam int BIT_IDX_W     = 5;
	localparam int ADDR_W        = 32;
	localparam int REL_WORD_W    = ADDR_W - FRAME_SHIFT - BIT_IDX_W;
	localparam int WIU_W         = 6;
	localparam int CFG_IDX_W     = 1;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_LOAD    = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_NULL  = 2'd2;
	localparam logic [1:0] STS_RANGE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS = 1'b1;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [ADDR_W-1:0]    frame_address;
		logic [BIT_IDX_W-1:0] word_index;
		logic [WORD_BITS-1:0] word_value;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [1:0]        status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_REL_MOD,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       latch_req;
		logic       scan_start;
		logic       scan_step;
		logic       alloc_commit;
		logic       rel_read;
		logic       rel_commit;
		logic       load_commit;
		logic       res_wr;
		logic [1:0] res_status;
		logic       out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       rel_null;
		logic       rel_range;
		logic       load_range;
		logic       scan_found;
		logic       scan_empty;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/bpfa_dp.sv
// datapath: config registers, bitmap memory, scan pointer and result registers
`default_nettype none

module bpfa_dp #(
	parameter int MAP_WORDS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                  cfg_data,
	input  wire bpfa_pkg::req_t               req,
	input  wire bpfa_pkg::dp_cmd_t            cmd,
	output bpfa_pkg::dp_sts_t                 sts,
	output bpfa_pkg::rsp_t                    rsp
);
	import bpfa_pkg::*;

	localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CNT_W = $clog2(MAP_WORDS + 1);
	localparam int NW    = (CNT_W > WIU_W) ? CNT_W : WIU_W;

	function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
		logic [BIT_IDX_W-1:0] r;
		r = BIT_IDX_W'(WORD_BITS - 1);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = BIT_IDX_W'(i);
			end
		end
		return r;
	endfunction

	logic [ADDR_W-1:0]    base_q;
	logic [WIU_W-1:0]     words_q;
	req_t                 req_q;
	logic [NW-1:0]        ptr_q;
	logic [IDX_W-1:0]     chk_idx_q;
	logic                 pend_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic [1:0]           res_status_q;
	rsp_t                 out_q;
	logic [WORD_BITS-1:0] mem [MAP_WORDS];

	logic [NW-1:0]                words_ext;
	logic [NW-1:0]                n_eff;
	logic                         ptr_live;
	logic [ADDR_W-1:0]            rel_off;
	logic [REL_WORD_W-1:0]        rel_word;
	logic [BIT_IDX_W-1:0]         rel_bit;
	logic [IDX_W-1:0]             rel_idx;
	logic [BIT_IDX_W-1:0]         alloc_bit;
	logic [ADDR_W-1:0]            alloc_addr;
	logic                         mem_re;
	logic [IDX_W-1:0]             mem_ra;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_wa;
	logic [WORD_BITS-1:0]         mem_wd;

	// effective word count, saturated to the memory depth
	assign words_ext = NW'(words_q);
	assign n_eff     = (words_ext > NW'(MAP_WORDS)) ? NW'(MAP_WORDS) : words_ext;
	assign ptr_live  = (ptr_q < n_eff);

	// release decode
	assign rel_off  = req_q.frame_address - base_q;
	assign rel_word = rel_off[ADDR_W-1:FRAME_SHIFT+BIT_IDX_W];
	assign rel_bit  = rel_off[FRAME_SHIFT+BIT_IDX_W-1:FRAME_SHIFT];
	assign rel_idx  = IDX_W'(rel_word);

	// allocation result
	assign alloc_bit  = lowest_set(rdata_q);
	assign alloc_addr = base_q + (ADDR_W'({chk_idx_q, alloc_bit}) << FRAME_SHIFT);

	always_comb begin
		mem_re = 1'b0;
		mem_ra = ptr_q[IDX_W-1:0];
		if (cmd.rel_read) begin
			mem_re = 1'b1;
			mem_ra = rel_idx;
		end else if (cmd.scan_step && ptr_live) begin
			mem_re = 1'b1;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = IDX_W'(req_q.word_index);
		mem_wd = req_q.word_value;
		if (cmd.load_commit) begin
			mem_we = 1'b1;
		end else if (cmd.alloc_commit) begin
			mem_we = 1'b1;
			mem_wa = chk_idx_q;
			mem_wd = rdata_q & ~(WORD_BITS'(1) << alloc_bit);
		end else if (cmd.rel_commit) begin
			mem_we = 1'b1;
			mem_wa = rel_idx;
			mem_wd = rdata_q | (WORD_BITS'(1) << rel_bit);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			words_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE:  base_q  <= cfg_data;
				REG_WORDS: words_q <= cfg_data[WIU_W-1:0];
				default:   base_q  <= base_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.scan_start) begin
			ptr_q  <= '0;
			pend_q <= 1'b0;
		end else if (cmd.scan_step) begin
			pend_q <= ptr_live;
			if (ptr_live) begin
				ptr_q <= ptr_q + NW'(1);
			end
		end else if (cmd.alloc_commit) begin
			// scan over, nothing left pending
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req;
		end
		if (cmd.scan_step && ptr_live) begin
			chk_idx_q <= ptr_q[IDX_W-1:0];
		end
		if (cmd.alloc_commit) begin
			res_addr_q   <= alloc_addr;
			res_status_q <= STS_OK;
		end else if (cmd.res_wr) begin
			res_addr_q   <= '0;
			res_status_q <= cmd.res_status;
		end
		if (cmd.out_load) begin
			out_q.result_address <= res_addr_q;
			out_q.status         <= res_status_q;
		end
	end

	assign sts.cmd        = req_q.cmd;
	assign sts.rel_null   = (req_q.frame_address == '0);
	assign sts.rel_range  = (32'(rel_word) >= 32'(n_eff));
	assign sts.load_range = (32'(req_q.word_index) >= 32'(MAP_WORDS));
	assign sts.scan_found = pend_q && (rdata_q != '0);
	assign sts.scan_empty = !pend_q && !ptr_live;
	assign rsp            = out_q;

	a_commit_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc_commit |-> sts.scan_found)
		else $error("allocation committed without a nonzero bitmap word");

	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we))
		else $error("bitmap memory read and written in the same cycle");

	a_pend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (NW'(chk_idx_q) < n_eff))
		else $error("scan checked a word outside the managed range");

endmodule

`default_nettype wire

// File: rtl/bpfa_ctrl.sv
// controller state machine sequencing each transaction through the datapath
`default_nettype none

module bpfa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	input  wire bpfa_pkg::dp_sts_t   sts,
	output bpfa_pkg::dp_cmd_t        cmd
);
	import bpfa_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				case (sts.cmd)
					CMD_ALLOC: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					CMD_RELEASE: begin
						if (sts.rel_null) begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = STS_NULL;
						end else if (sts.rel_range) begin
							cmd.res_wr     = 1'b1;
							cmd.res_status = STS_RANGE;
						end else begin
							cmd.rel_read = 1'b1;
							state_d      = S_REL_MOD;
						end
					end
					CMD_LOAD: begin
						cmd.res_wr = 1'b1;
						if (sts.load_range) begin
							cmd.res_status = STS_RANGE;
						end else begin
							cmd.load_commit = 1'b1;
							cmd.res_status  = STS_OK;
						end
					end
					default: begin
						cmd.res_wr     = 1'b1;
						cmd.res_status = STS_OK;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_found) begin
					cmd.alloc_commit = 1'b1;
					state_d          = S_FINISH;
				end else if (sts.scan_empty) begin
					cmd.res_wr     = 1'b1;
					cmd.res_status = STS_EMPTY;
					state_d        = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_REL_MOD: begin
				cmd.rel_commit = 1'b1;
				cmd.res_wr     = 1'b1;
				cmd.res_status = STS_OK;
				state_d        = S_FINISH;
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("result load did not raise the output valid");

	a_one_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.alloc_commit, cmd.rel_commit, cmd.load_commit}) <= 1)
		else $error("more than one bitmap write commanded in a cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |-> !cmd.out_load)
		else $error("pending result overwritten while stalled");

endmodule

`default_nettype wire

// File: rtl/bitmap_page_frame_allocator_top.sv
// top level of the bitmap page frame allocator
//
// usage: a request transaction (req_valid/req_ready, payload req) carries a
// command: allocate, release or load one bitmap word. every request yields
// exactly one response transaction (rsp_valid/rsp_ready, payload rsp) holding
// the allocated frame address (zero otherwise) and a status code.
// configuration: cfg_we writes cfg_data into base_address (index 0) or
// words_in_use (index 1); write only while no request is in flight.
// timing: the controller handles one request at a time. a release does a
// read-modify-write of one bitmap word. an allocate scans the managed words
// from word 0 upward until one holds a free frame or the effective word count
// is reached; the scan reads one word per cycle from the single-port bitmap
// memory, so an allocate takes longer the later its free frame sits.
// reset: arst_n clears the controller, base_address and words_in_use; the
// bitmap itself is undefined until loaded, so load every managed word first.
// stall: a finished response sits in the output register; a new request is
// still accepted, and the next response waits until the old one is taken.
`default_nettype none

module bitmap_page_frame_allocator_top #(
	parameter int MAP_WORDS = bpfa_pkg::MAP_WORDS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire bpfa_pkg::req_t                 req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output bpfa_pkg::rsp_t                      rsp
);
	import bpfa_pkg::*;

	// command and status bundles between controller and datapath
	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// sequencing: decode, word scan, read-modify-write, result hand-off
	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// bitmap memory, config registers, address math and output register
	bpfa_dp #(
		.MAP_WORDS (MAP_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
